FILE: design/efs_pkg.sv
// Shared types and constants of the elevator floor scheduler.
// Holds the item and result structs and the controller/datapath interface.
// No dependencies.
package efs_pkg;

    // Action codes of an input item.
    localparam logic [1:0] ACT_CAR       = 2'd0;
    localparam logic [1:0] ACT_HALL_UP   = 2'd1;
    localparam logic [1:0] ACT_HALL_DOWN = 2'd2;
    localparam logic [1:0] ACT_RUN       = 2'd3;

    // Kind codes of a result.
    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_HALT = 2'd1;
    localparam logic [1:0] KIND_STOP = 2'd2;

    // Most results one run may produce, the final stop included.
    localparam int MAX_RES = 50;

    // Top floor after reset.
    localparam logic [3:0] TOP_RESET = 4'd15;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] floor;
    } t_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] floor_res;
        logic       last;
    } t_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // take the item on the input ports
        logic decide;     // choose the first direction of a run
        logic step;       // walk one floor step
        logic emit_stop;  // send the final stop result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic run_go;     // the item is a run from a valid floor
        logic no_dir;     // nothing to serve, the run ends at once
        logic walk_end;   // this step ends the walk
    } t_sts;

endpackage

FILE: design/efs_ctrl.sv
// Controller state machine of the elevator floor scheduler.
// Sequences accept, direction choice, floor walk and stop; uses efs_pkg.
module efs_ctrl
    import efs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WALK,
        ST_STOP
    } t_state;

    t_state r_state;
    logic   r_busy;

    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = (r_state == ST_IDLE) && i_start;
        o_cmd.decide    = (r_state == ST_SCAN);
        o_cmd.step      = (r_state == ST_WALK);
        o_cmd.emit_stop = (r_state == ST_STOP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_start && i_sts.run_go) begin
                        r_state <= ST_SCAN;
                        r_busy  <= 1'b1;
                    end
                end
                ST_SCAN: begin
                    r_state <= i_sts.no_dir ? ST_STOP : ST_WALK;
                end
                ST_WALK: begin
                    if (i_sts.walk_end) begin
                        r_state <= ST_STOP;
                    end
                end
                ST_STOP: begin
                    r_state <= ST_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy = r_busy;

endmodule

FILE: design/efs_dp.sv
// Datapath of the elevator floor scheduler: call flags, car position,
// direction, step and result counters, and the result register; uses efs_pkg.
module efs_dp
    import efs_pkg::*;
#(
    parameter int FLOORS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_item,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output logic       o_res_valid,
    output t_res       o_res
);

    localparam int STEP_LIMIT = 8 * FLOORS + 8;
    localparam int SW         = $clog2(STEP_LIMIT + 1);

    logic [3:0]        r_top;
    logic [FLOORS-1:0] r_car, r_up, r_down;
    logic [FLOORS-1:0] n_car, n_up, n_down;
    logic [3:0]        r_f, n_f;
    logic [3:0]        r_pos, n_pos;
    logic              r_dir_up, n_dir_up;
    logic [SW-1:0]     r_steps, n_steps;
    logic [5:0]        r_cnt, n_cnt;
    logic              r_res_valid, n_res_valid;
    t_res              r_res, n_res;

    // One-hot code of a floor.
    function automatic logic [FLOORS-1:0] onehot(input logic [3:0] fl);
        logic [FLOORS-1:0] v;
        for (int i = 0; i < FLOORS; i++) begin
            v[i] = (i == int'(fl));
        end
        return v;
    endfunction

    // Floors strictly above fl and not above top.
    function automatic logic [FLOORS-1:0] above(input logic [3:0] fl,
                                                input logic [3:0] top);
        logic [FLOORS-1:0] v;
        for (int i = 0; i < FLOORS; i++) begin
            v[i] = (i > int'(fl)) && (i <= int'(top));
        end
        return v;
    endfunction

    function automatic logic [FLOORS-1:0] below(input logic [3:0] fl);
        logic [FLOORS-1:0] v;
        for (int i = 0; i < FLOORS; i++) begin
            v[i] = (i < int'(fl));
        end
        return v;
    endfunction

    function automatic logic [FLOORS-1:0] upto(input logic [3:0] top);
        logic [FLOORS-1:0] v;
        for (int i = 0; i < FLOORS; i++) begin
            v[i] = (i <= int'(top));
        end
        return v;
    endfunction

    function automatic logic [5:0] low_idx(input logic [FLOORS-1:0] v);
        logic [5:0] idx;
        idx = '0;
        for (int i = FLOORS - 1; i >= 0; i--) begin
            if (v[i]) idx = 6'(i);
        end
        return idx;
    endfunction

    function automatic logic [5:0] high_idx(input logic [FLOORS-1:0] v);
        logic [5:0] idx;
        idx = '0;
        for (int i = 0; i < FLOORS; i++) begin
            if (v[i]) idx = 6'(i);
        end
        return idx;
    endfunction

    // Effective top floor, never beyond the last built floor.
    logic [3:0] top_eff;
    assign top_eff = (int'(r_top) < FLOORS - 1) ? r_top : 4'(FLOORS - 1);

    logic              in_range;
    logic [FLOORS-1:0] oh_in;
    assign in_range = (i_item.floor <= top_eff);
    assign oh_in    = onehot(i_item.floor);

    // Direction choice from the current floor.
    logic [FLOORS-1:0] m_above, m_below, m_range, oh_f;
    logic [FLOORS-1:0] near_up_v, near_dn_v, far_up_v, far_dn_v;
    logic [5:0]        ud1, dd1, dd2, ud2, f_ext;
    logic              go_up, dir_none;

    assign m_above   = above(r_f, top_eff);
    assign m_below   = below(r_f);
    assign m_range   = upto(top_eff);
    assign oh_f      = onehot(r_f);
    assign f_ext     = {2'b00, r_f};
    assign near_up_v = (r_up | r_car) & m_above;
    assign near_dn_v = (r_down | r_car) & m_below;
    assign far_dn_v  = r_up & m_below;
    assign far_up_v  = r_down & m_above;
    assign ud1       = low_idx(near_up_v) - f_ext;
    assign dd1       = f_ext - high_idx(near_dn_v);
    assign dd2       = f_ext - low_idx(far_dn_v);
    assign ud2       = high_idx(far_up_v) - f_ext;

    always_comb begin
        go_up    = 1'b0;
        dir_none = 1'b0;
        if ((|near_up_v) && (|near_dn_v)) begin
            go_up = (ud1 <= dd1);
        end else if (|near_up_v) begin
            go_up = 1'b1;
        end else if (|near_dn_v) begin
            go_up = 1'b0;
        end else if (!(|far_dn_v)) begin
            dir_none = 1'b1;
        end else if (!(|far_up_v)) begin
            go_up = 1'b0;
        end else begin
            go_up = (dd2 >= ud2);
        end
    end

    // Next floor in the walk direction.
    logic [3:0]        g;
    logic [FLOORS-1:0] oh_g;
    assign g    = r_dir_up ? 4'(r_f + 4'd1) : 4'(r_f - 4'd1);
    assign oh_g = onehot(g);

    always_comb begin
        logic [FLOORS-1:0] up1, dn1, up2, dn2, car2;
        logic              halt;
        n_car       = r_car;
        n_up        = r_up;
        n_down      = r_down;
        n_f         = r_f;
        n_pos       = r_pos;
        n_dir_up    = r_dir_up;
        n_steps     = r_steps;
        n_cnt       = r_cnt;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_sts       = '0;
        up1         = r_up & ~oh_f;
        dn1         = r_down & ~oh_f;
        up2         = '0;
        dn2         = '0;
        car2        = '0;
        halt        = 1'b0;

        o_sts.run_go = in_range && (i_item.action == ACT_RUN);
        o_sts.no_dir = dir_none;

        if (i_cmd.accept && in_range) begin
            case (i_item.action)
                ACT_CAR:       n_car  = r_car | oh_in;
                ACT_HALL_UP:   n_up   = r_up | oh_in;
                ACT_HALL_DOWN: n_down = r_down | oh_in;
                ACT_RUN: begin
                    n_car       = r_car & ~oh_in;
                    n_up        = r_up & ~oh_in;
                    n_down      = r_down & ~oh_in;
                    n_f         = i_item.floor;
                    n_pos       = i_item.floor;
                    n_steps     = '0;
                    n_cnt       = 6'd1;
                    n_res_valid = 1'b1;
                    n_res       = '{kind: KIND_ECHO, floor_res: i_item.floor, last: 1'b0};
                end
                default: n_car = r_car;
            endcase
        end

        if (i_cmd.decide) begin
            n_dir_up = go_up;
        end

        if (i_cmd.step) begin
            n_steps = SW'(r_steps + 1'b1);
            if (r_steps >= SW'(STEP_LIMIT)) begin
                o_sts.walk_end = 1'b1;
            end else if (!r_dir_up) begin
                n_down = dn1;
                if (r_f == 4'd0) begin
                    // Bottom floor: turn around without moving.
                    n_car    = r_car & ~oh_f;
                    n_dir_up = 1'b1;
                end else begin
                    halt = (|((dn1 | r_car) & oh_g)) || ((|(r_up & oh_g)) && (r_f == 4'd1));
                    if (halt && (r_cnt >= 6'(MAX_RES - 1))) begin
                        o_sts.walk_end = 1'b1;
                    end else begin
                        if (halt) begin
                            dn2         = dn1 & ~oh_g;
                            car2        = r_car & ~oh_g;
                            n_down      = dn2;
                            n_car       = car2;
                            n_pos       = g;
                            n_cnt       = 6'(r_cnt + 6'd1);
                            n_res_valid = 1'b1;
                            n_res       = '{kind: KIND_HALT, floor_res: g, last: 1'b0};
                            o_sts.walk_end = !(|((r_up | dn2 | car2) & m_range & ~oh_f));
                        end
                        n_f = g;
                    end
                end
            end else begin
                n_up = up1;
                if (r_f >= top_eff) begin
                    // Top floor: turn around without moving.
                    n_car    = r_car & ~oh_f;
                    n_dir_up = 1'b0;
                end else begin
                    halt = (|((up1 | r_car) & oh_g)) || ((|(r_down & oh_g)) && (g == top_eff));
                    if (halt && (r_cnt >= 6'(MAX_RES - 1))) begin
                        o_sts.walk_end = 1'b1;
                    end else begin
                        if (halt) begin
                            up2         = up1 & ~oh_g;
                            car2        = r_car & ~oh_g;
                            n_up        = up2;
                            n_car       = car2;
                            n_pos       = g;
                            n_cnt       = 6'(r_cnt + 6'd1);
                            n_res_valid = 1'b1;
                            n_res       = '{kind: KIND_HALT, floor_res: g, last: 1'b0};
                            o_sts.walk_end = !(|((up2 | r_down | car2) & m_range & ~oh_f));
                        end
                        n_f = g;
                    end
                end
            end
        end

        if (i_cmd.emit_stop) begin
            n_res_valid = 1'b1;
            n_res       = '{kind: KIND_STOP, floor_res: r_pos, last: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= TOP_RESET;
            r_car       <= '0;
            r_up        <= '0;
            r_down      <= '0;
            r_pos       <= '0;
            r_f         <= '0;
            r_dir_up    <= 1'b0;
            r_steps     <= '0;
            r_cnt       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_top <= i_cfg_wdata;
            end
            r_car       <= n_car;
            r_up        <= n_up;
            r_down      <= n_down;
            r_pos       <= n_pos;
            r_f         <= n_f;
            r_dir_up    <= n_dir_up;
            r_steps     <= n_steps;
            r_cnt       <= n_cnt;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

FILE: design/elevator_floor_scheduler.sv
// Elevator floor scheduler top level. A call transaction leaves the block idle; a run
// shows its start echo in the cycle after acceptance. A run keeps busy high through the
// direction scan, the floor walk and the stop state; the next transaction is taken once
// busy is low again. Results cannot be stalled. Reset (synchronous, active low) clears all
// call flags, rests the car at floor 0 and sets the top floor to 15. Uses efs_pkg, efs_ctrl,
// efs_dp.
module elevator_floor_scheduler
    import efs_pkg::*;
#(
    parameter int FLOORS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Command channel: a transaction is taken when start is high and busy is low.
    input  logic       i_start,
    input  t_item      i_item,
    output logic       o_busy,
    // Result channel: each result is valid for exactly one cycle.
    output logic       o_res_valid,
    output t_res       o_res,
    // Top floor register; the user writes it only while the block is idle, the block has no guard.
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata
);

    // The controller walks through idle, direction scan, floor walk and stop.
    // Call transactions are absorbed in the idle state, so back-to-back calls run
    // at one per cycle; only a run from a floor within range raises busy.
    // The echo is on the ports during the scan cycle, and the final stop result is
    // on the ports in the first idle cycle after busy falls.
    t_cmd cmd;
    t_sts sts;

    efs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // The datapath holds the three per-floor call flag sets, the car floor and
    // direction, and the result register. Each walk step serves at most one floor,
    // so at most one result leaves per cycle and the final stop follows the walk.
    efs_dp #(
        .FLOORS (FLOORS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

FILE: design/efs_chk.sv
// Port-level checker of the elevator floor scheduler and its bind statement.
// Depends on efs_pkg and the elevator_floor_scheduler top level.
module efs_chk
    import efs_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_busy,
    input logic o_res_valid,
    input t_res o_res
);

    // The final stop result appears exactly as the block returns to idle.
    a_stop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.last |-> !o_busy)
        else $error("stop result while busy");

    // Echo and halt results belong to a run in progress.
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.last |-> o_busy)
        else $error("non-final result while idle");

    // The last flag marks the stop kind and nothing else.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.last == (o_res.kind == KIND_STOP)) && (o_res.kind <= KIND_STOP))
        else $error("result kind and last flag disagree");

    // A run never ends without its stop result.
    a_end_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> o_res_valid && o_res.last)
        else $error("run ended without a stop result");

endmodule

bind elevator_floor_scheduler efs_chk u_efs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_busy      (o_busy),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the elevator floor scheduler (elevator_floor_scheduler).
// Holds a behavioral model of the call flags and car motion, directed and random traffic.
// Depends on efs_pkg and the scheduler RTL.
module tb;
    import efs_pkg::*;

    localparam int FLOORS      = 16;
    localparam int STEP_LIMIT  = 8 * FLOORS + 8;
    // A slow correct run walks at most STEP_LIMIT floors without a result.
    // This leaves a wide margin.
    localparam int STALL_LIMIT = 2000;

    // Direction of the car while the model walks a run.
    typedef enum logic [1:0] {
        MOTION_DOWN,
        MOTION_UP,
        MOTION_STOP
    } t_motion;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_start;
    t_item      i_item;
    logic       o_busy;
    logic       o_res_valid;
    t_res       o_res;
    logic       i_cfg_we;
    logic [3:0] i_cfg_wdata;

    // Model state: the three flag sets, the rest floor and the top floor register.
    logic [FLOORS-1:0] car_buttons;
    logic [FLOORS-1:0] hall_up;
    logic [FLOORS-1:0] hall_down;
    logic [3:0]        rest_floor;
    logic [3:0]        top_floor_cfg;

    t_res expected_results[$];
    int   fail_count     = 0;
    int   stalled_cycles = 0;
    bit   allow_idle     = 1'b1;

    elevator_floor_scheduler #(
        .FLOORS(FLOORS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_item     (i_item),
        .o_busy     (o_busy),
        .o_res_valid(o_res_valid),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    //------------------------------------------------------------------------
    // Model of the scheduler
    //------------------------------------------------------------------------

    task automatic queue_result(input logic [1:0] kind, input int fl, input logic last);
        t_res r;
        r.kind      = kind;
        r.floor_res = fl[3:0];
        r.last      = last;
        expected_results.push_back(r);
    endtask

    // First direction of a run: +1 up, -1 down, 0 when there is nothing to serve.
    function automatic int choose_direction(input int f, input int n);
        int i, none, dist_up, dist_down;
        none      = n + 1;
        dist_up   = none;
        dist_down = none;
        // Nearest request the car would serve going up, then going down.
        for (i = f + 1; i <= n; i++)
            if (hall_up[i] || car_buttons[i]) begin
                dist_up = i - f;
                break;
            end
        for (i = f; i > 0; i--)
            if (hall_down[i-1] || car_buttons[i-1]) begin
                dist_down = f - (i - 1);
                break;
            end
        // A tie between two found requests goes up.
        if (dist_up == dist_down && dist_up != none) return 1;
        if (dist_up > dist_down) return -1;
        if (dist_down > dist_up) return 1;
        // Nothing in either sweep: look for an up call below and a down call above.
        for (i = 0; i < f; i++)
            if (hall_up[i]) begin
                dist_down = f - i;
                break;
            end
        for (i = n; i > f; i--)
            if (hall_down[i]) begin
                dist_up = i - f;
                break;
            end
        if (dist_down == none) return 0;
        return (dist_down >= dist_up) ? 1 : -1;
    endfunction

    // True when any floor other than f still has a flag set.
    function automatic bit calls_elsewhere(input int f, input int n);
        int i;
        for (i = 0; i <= n; i++)
            if (i != f && (hall_up[i] || hall_down[i] || car_buttons[i])) return 1'b1;
        return 1'b0;
    endfunction

    // Updates the model for one accepted transaction and queues the results it causes.
    task automatic predict_results(input t_item it);
        int      n, f, g, steps, cnt, dir;
        t_motion motion;
        n = (top_floor_cfg < FLOORS - 1) ? int'(top_floor_cfg) : FLOORS - 1;
        // Calls and runs above the top floor are dropped without any effect.
        if (it.floor > n) return;
        if (it.action == ACT_CAR) begin
            car_buttons[it.floor] = 1'b1;
            return;
        end
        if (it.action == ACT_HALL_UP) begin
            hall_up[it.floor] = 1'b1;
            return;
        end
        if (it.action == ACT_HALL_DOWN) begin
            hall_down[it.floor] = 1'b1;
            return;
        end

        f     = it.floor;
        steps = 0;
        queue_result(KIND_ECHO, f, 1'b0);
        cnt            = 1;
        rest_floor     = it.floor;
        car_buttons[f] = 1'b0;
        hall_up[f]     = 1'b0;
        hall_down[f]   = 1'b0;
        dir    = choose_direction(f, n);
        motion = (dir > 0) ? MOTION_UP : ((dir < 0) ? MOTION_DOWN : MOTION_STOP);

        while (motion != MOTION_STOP) begin
            steps++;
            if (steps > STEP_LIMIT) break;
            if (motion == MOTION_DOWN) begin
                hall_down[f] = 1'b0;
                if (f == 0) begin
                    car_buttons[0] = 1'b0;
                    motion = MOTION_UP;
                    continue;
                end
                g = f - 1;
                // Going down, an up call is served only at the ground floor.
                if (hall_down[g] || car_buttons[g] || (hall_up[g] && f == 1)) begin
                    if (cnt >= MAX_RES - 1) break;
                    hall_down[g]   = 1'b0;
                    car_buttons[g] = 1'b0;
                    queue_result(KIND_HALT, g, 1'b0);
                    cnt++;
                    rest_floor = g[3:0];
                    if (!calls_elsewhere(f, n)) break;
                end
                f = g;
            end else begin
                hall_up[f] = 1'b0;
                if (f >= n) begin
                    car_buttons[f] = 1'b0;
                    motion = MOTION_DOWN;
                    continue;
                end
                g = f + 1;
                // Going up, a down call is served only at the top floor.
                if (hall_up[g] || car_buttons[g] || (hall_down[g] && g == n)) begin
                    if (cnt >= MAX_RES - 1) break;
                    hall_up[g]     = 1'b0;
                    car_buttons[g] = 1'b0;
                    queue_result(KIND_HALT, g, 1'b0);
                    cnt++;
                    rest_floor = g[3:0];
                    if (!calls_elsewhere(f, n)) break;
                end
                f = g;
            end
        end
        queue_result(KIND_STOP, rest_floor, 1'b1);
    endtask

    //------------------------------------------------------------------------
    // Driving
    //------------------------------------------------------------------------

    // Offers one transaction and returns at the edge that accepts it. start is left
    // high, so a following transaction goes out back to back unless idle cycles are drawn.
    task automatic send_item(input logic [1:0] action, input logic [3:0] fl);
        t_item it;
        it.action = action;
        it.floor  = fl;
        if (allow_idle) begin
            while ($urandom_range(99) < 14) begin
                i_start <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_start <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_busy);
        predict_results(it);
    endtask

    // Writes the top floor once the block has gone quiet. A call leaves no result
    // behind, so the task also waits out the work of a last call before the write.
    task automatic set_top_floor(input logic [3:0] value);
        i_start <= 1'b0;
        while (expected_results.size() != 0 || o_busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        top_floor_cfg  = value;
    endtask

    // Mostly a floor inside the building, now and then any floor at all.
    function automatic logic [3:0] random_floor(input logic [3:0] top);
        if ($urandom_range(9) == 0) return 4'($urandom_range(15));
        return 4'($urandom_range(int'(top)));
    endfunction

    //------------------------------------------------------------------------
    // Checking: every result transaction is compared with the oldest expectation.
    //------------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_valid) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: kind %0d floor_res %0d last %0d",
                       o_res.kind, o_res.floor_res, o_res.last);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_res.kind !== want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, o_res.kind);
                    fail_count++;
                end
                if (o_res.floor_res !== want.floor_res) begin
                    $error("floor_res: expected %0d, actual %0d",
                           want.floor_res, o_res.floor_res);
                    fail_count++;
                end
                if (o_res.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, o_res.last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither a command nor a result transaction happens.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_res_valid) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial begin
        wait (stalled_cycles >= STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    //------------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------------

    // Runs with the reset top floor of 15 that hit each direction rule.
    task automatic test_direction_rules();
        // Empty building: the car stops at once.
        send_item(ACT_RUN, 4'd0);
        // Up to the top, a down call served there, back down to an up call on the ground.
        send_item(ACT_CAR, 4'd15);
        send_item(ACT_HALL_DOWN, 4'd15);
        send_item(ACT_HALL_UP, 4'd0);
        send_item(ACT_CAR, 4'd7);
        send_item(ACT_RUN, 4'd7);
        // Two requests at the same distance: up wins.
        send_item(ACT_CAR, 4'd5);
        send_item(ACT_CAR, 4'd9);
        send_item(ACT_RUN, 4'd7);
        // Only an up call below and a down call above, equally far: up.
        send_item(ACT_HALL_UP, 4'd2);
        send_item(ACT_HALL_DOWN, 4'd12);
        send_item(ACT_RUN, 4'd7);
        // Same shape but the up call below is nearer: down.
        send_item(ACT_HALL_UP, 4'd6);
        send_item(ACT_HALL_DOWN, 4'd14);
        send_item(ACT_RUN, 4'd8);
        // From the top down to the ground floor.
        send_item(ACT_CAR, 4'd0);
        send_item(ACT_RUN, 4'd15);
    endtask

    // Smallest building, floors 0 and 1, with calls and runs above the top floor.
    task automatic test_two_floor_building();
        set_top_floor(4'd1);
        send_item(ACT_CAR, 4'd9);
        send_item(ACT_HALL_UP, 4'd0);
        send_item(ACT_HALL_DOWN, 4'd1);
        send_item(ACT_CAR, 4'd1);
        send_item(ACT_RUN, 4'd1);
        send_item(ACT_HALL_DOWN, 4'd1);
        send_item(ACT_RUN, 4'd0);
        send_item(ACT_RUN, 4'd12);
        send_item(ACT_HALL_UP, 4'd1);
        send_item(ACT_RUN, 4'd0);
    endtask

    // Random call bursts, each mostly closed by a run, over several building sizes.
    // One phase runs with no idle gaps at all.
    task automatic test_random_traffic();
        int         phase, k, calls, sent;
        logic [3:0] top, fl;
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0, 3:    top = 4'd15;
                1:       top = 4'd1;
                2:       top = 4'($urandom_range(2, 14));
                default: top = 4'd8;
            endcase
            allow_idle = (phase != 3);
            set_top_floor(top);
            sent = 0;
            while (sent < 26) begin
                calls = $urandom_range(0, 5);
                for (k = 0; k < calls; k++) begin
                    fl = random_floor(top);
                    send_item(2'($urandom_range(2)), fl);
                    if (fl <= top) sent++;
                end
                // Now and then a burst is left without a run, so calls pile up.
                if ($urandom_range(9) != 0) begin
                    fl = random_floor(top);
                    send_item(ACT_RUN, fl);
                    if (fl <= top) sent++;
                end
            end
        end
        allow_idle = 1'b1;
    endtask

    //------------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------------

    initial begin
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_item        = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        car_buttons   = '0;
        hall_up       = '0;
        hall_down     = '0;
        rest_floor    = '0;
        top_floor_cfg = TOP_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_direction_rules();
        test_two_floor_building();
        test_random_traffic();

        // Let the last run finish and let the block settle.
        i_start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/efs_pkg.sv
design/efs_ctrl.sv
design/efs_dp.sv
design/elevator_floor_scheduler.sv
design/efs_chk.sv
bench/tb.sv
